// File: src/fvt_pkg.sv
// Shared types and constants for the fixed-point affine vertex transform.
// Item structs, function codes and the coefficient matrix type.
// No dependencies.
`default_nettype none

package fvt_pkg;

	localparam int unsigned MAT_WORDS = 12;
	localparam int unsigned MAT_COLS  = 3;
	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned COEF_W    = 32;
	localparam int unsigned VEC_W     = 16;

	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_POINT = 2'd1;
	localparam logic [1:0] FUNC_DIR   = 2'd2;

	// Base word of each matrix row (row * 3)
	localparam logic [3:0] ROW_X = 4'd0;
	localparam logic [3:0] ROW_Y = 4'd3;
	localparam logic [3:0] ROW_Z = 4'd6;
	localparam logic [3:0] ROW_T = 4'd9;

	typedef struct packed {
		logic        [1:0]        func;
		logic        [3:0]        coef_index;
		logic signed [COEF_W-1:0] coef_value;
		logic signed [VEC_W-1:0]  vec_x;
		logic signed [VEC_W-1:0]  vec_y;
		logic signed [VEC_W-1:0]  vec_z;
	} cmd_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] out_x;
		logic signed [VEC_W-1:0] out_y;
		logic signed [VEC_W-1:0] out_z;
	} res_t;

	typedef logic [MAT_WORDS-1:0][COEF_W-1:0] coef_mat_t;

	typedef struct packed {
		logic s2_en;
		logic out_en;
	} pipe_ctrl_t;

endpackage

`default_nettype wire

// File: src/fixed_affine_vertex_transform.sv
// Fixed-point affine vertex transform, top level.
// Pipeline: input, product and sum registers lie between an accepted transform and its result.
// Throughput: one transaction per cycle while res_stall is low; each stage advances when the one after it is free.
// Load transactions write the matrix at acceptance and produce no result.
// Reset (arst_n low, asynchronous): matrix cleared to zero, all stages empty.
// Depends on fvt_pkg, fvt_coef_store, fvt_datapath.
`default_nettype none

module fixed_affine_vertex_transform (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    cmd_valid,
	output logic         cmd_stall,
	input  wire fvt_pkg::cmd_t cmd,
	output logic         res_valid,
	input  wire logic    res_stall,
	output fvt_pkg::res_t res
);

	logic v_s1, v_s2, res_valid_q;
	logic point_s1;
	logic signed [fvt_pkg::VEC_W-1:0] x_s1, y_s1, z_s1;
	logic adv_out, adv2, adv1, accept, is_xform;
	fvt_pkg::pipe_ctrl_t ctrl;
	fvt_pkg::coef_mat_t  mat;

	assign adv_out = !res_valid_q || !res_stall;
	assign adv2    = !v_s2 || adv_out;
	assign adv1    = !v_s1 || adv2;
	assign cmd_stall = !adv1;
	assign accept  = cmd_valid && adv1;
	assign is_xform = (cmd.func == fvt_pkg::FUNC_POINT) || (cmd.func == fvt_pkg::FUNC_DIR);

	assign ctrl = '{s2_en: adv2 && v_s1, out_en: adv_out && v_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= accept && is_xform;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv_out) begin
				res_valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_xform) begin
			point_s1 <= (cmd.func == fvt_pkg::FUNC_POINT);
			x_s1     <= cmd.vec_x;
			y_s1     <= cmd.vec_y;
			z_s1     <= cmd.vec_z;
		end
	end

	fvt_coef_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept && (cmd.func == fvt_pkg::FUNC_LOAD)),
		.wr_index (cmd.coef_index),
		.wr_data  (cmd.coef_value),
		.mat      (mat)
	);

	fvt_datapath u_dp (
		.clk      (clk),
		.ctrl     (ctrl),
		.point_s1 (point_s1),
		.x_s1     (x_s1),
		.y_s1     (y_s1),
		.z_s1     (z_s1),
		.mat      (mat),
		.res      (res)
	);

	assign res_valid = res_valid_q;

	// Stall only while the input stage holds a transform that cannot move
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (v_s1 && v_s2 && res_valid_q && res_stall))
		else $error("input stalled with room in the pipe");

	// A blocked stage-1 transform stays put
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv2) |=> v_s1)
		else $error("stage-1 transform lost while blocked");

	// A blocked stage-2 transform stays put
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !adv_out) |=> v_s2)
		else $error("stage-2 transform lost while blocked");

	// A load never creates a result entry
	a_load_no_res: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd.func == fvt_pkg::FUNC_LOAD)) |=> !v_s1)
		else $error("load entered the transform pipe");

endmodule

`default_nettype wire

// File: src/fvt_coef_store.sv
// Coefficient matrix storage: twelve 32-bit words, cleared at reset.
// One word written per load transaction; all words visible in parallel.
// Depends on fvt_pkg.
`default_nettype none

module fvt_coef_store (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [3:0]                     wr_index,
	input  wire logic [fvt_pkg::COEF_W-1:0]     wr_data,
	output fvt_pkg::coef_mat_t                  mat
);

	fvt_pkg::coef_mat_t mat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q <= '0;
		end else if (wr_en && (wr_index < 4'(fvt_pkg::MAT_WORDS))) begin
			// drop writes beyond the matrix
			mat_q[wr_index] <= wr_data;
		end
	end

	assign mat = mat_q;

endmodule

`default_nettype wire

// File: src/fvt_datapath.sv
// Multiply and sum stages: nine 32x32 wrapping products registered in
// stage 2, then per-column sum plus translation into the result register.
// Depends on fvt_pkg.
`default_nettype none

module fvt_datapath (
	input  wire logic                          clk,
	input  wire fvt_pkg::pipe_ctrl_t           ctrl,
	input  wire logic                          point_s1,
	input  wire logic signed [fvt_pkg::VEC_W-1:0] x_s1,
	input  wire logic signed [fvt_pkg::VEC_W-1:0] y_s1,
	input  wire logic signed [fvt_pkg::VEC_W-1:0] z_s1,
	input  wire fvt_pkg::coef_mat_t            mat,
	output fvt_pkg::res_t                      res
);

	logic signed [fvt_pkg::COEF_W-1:0] xe, ye, ze;
	logic [fvt_pkg::MAT_COLS-1:0][fvt_pkg::COEF_W-1:0] px_s2, py_s2, pz_s2, pt_s2;
	logic [fvt_pkg::MAT_COLS-1:0][fvt_pkg::COEF_W-1:0] px_d, py_d, pz_d, pt_d;
	logic [fvt_pkg::MAT_COLS-1:0][fvt_pkg::COEF_W-1:0] sum;
	fvt_pkg::res_t res_q;

	assign xe = fvt_pkg::COEF_W'(x_s1);
	assign ye = fvt_pkg::COEF_W'(y_s1);
	assign ze = fvt_pkg::COEF_W'(z_s1);

	always_comb begin
		for (int c = 0; c < fvt_pkg::MAT_COLS; c++) begin
			px_d[c] = mat[fvt_pkg::ROW_X + 4'(c)] * xe;
			py_d[c] = mat[fvt_pkg::ROW_Y + 4'(c)] * ye;
			pz_d[c] = mat[fvt_pkg::ROW_Z + 4'(c)] * ze;
			pt_d[c] = point_s1 ? mat[fvt_pkg::ROW_T + 4'(c)] : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.s2_en) begin
			px_s2 <= px_d;
			py_s2 <= py_d;
			pz_s2 <= pz_d;
			pt_s2 <= pt_d;
		end
	end

	// Wrap at 32 bits, keep bits 31..16 of the sum
	always_comb begin
		for (int c = 0; c < fvt_pkg::MAT_COLS; c++) begin
			sum[c] = px_s2[c] + py_s2[c] + pz_s2[c] + pt_s2[c];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_en) begin
			res_q.out_x <= sum[0][fvt_pkg::COEF_W-1:fvt_pkg::FRAC_BITS];
			res_q.out_y <= sum[1][fvt_pkg::COEF_W-1:fvt_pkg::FRAC_BITS];
			res_q.out_z <= sum[2][fvt_pkg::COEF_W-1:fvt_pkg::FRAC_BITS];
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire
